// File: design/rmed_pkg.sv
// Shared types and constants for the running median unit.
package rmed_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int SAMPLE_BITS = 16;
  localparam int MEDIAN_BITS = SAMPLE_BITS + 1;
  localparam int COUNT_BITS  = 7;

  // Payload of one input transfer.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } in_item_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic signed [MEDIAN_BITS-1:0] median_doubled;
    logic [COUNT_BITS-1:0]         sample_count;
    logic                          overflow;
  } out_item_t;

  // Per-cell insertion control, driven by the top level.
  typedef struct packed {
    logic insert;    // a sample is being taken into the store this cycle
    logic occupied;  // this cell holds a valid sample
    logic slot;      // this cell is the first free position
  } cell_ctrl_t;

endpackage

// File: design/rmed_cell.sv
// One storage cell of the sorted sample chain.
module rmed_cell (
  input  logic                                   clk,
  input  rmed_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [rmed_pkg::SAMPLE_BITS-1:0] new_sample,
  input  logic signed [rmed_pkg::SAMPLE_BITS-1:0] left_val,
  input  logic                                   left_gt,
  output logic signed [rmed_pkg::SAMPLE_BITS-1:0] val,
  output logic                                   gt
);

  logic signed [rmed_pkg::SAMPLE_BITS-1:0] val_r;
  logic signed [rmed_pkg::SAMPLE_BITS-1:0] val_nxt;
  logic                                    take;

  // A held sample above the new one moves one place to the right.
  assign gt   = ctrl.occupied && (val_r > new_sample);
  assign take = ctrl.insert && (gt || ctrl.slot);

  // The cell takes its left neighbor's sample if that one moves too,
  // otherwise this is where the new sample lands.
  always_comb begin
    val_nxt = val_r;
    if (take) begin
      val_nxt = left_gt ? left_val : new_sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: design/rmed_pick.sv
// Picks the two middle samples out of the cell row and sums them.
module rmed_pick #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic signed [rmed_pkg::SAMPLE_BITS-1:0] vals [CAPACITY],
  input  logic [IW-1:0]                           lo_idx,
  input  logic [IW-1:0]                           hi_idx,
  output logic signed [rmed_pkg::MEDIAN_BITS-1:0] sum
);

  logic [rmed_pkg::SAMPLE_BITS-1:0] lo_v;
  logic [rmed_pkg::SAMPLE_BITS-1:0] hi_v;

  // One-hot AND-OR selection across the cells.
  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IW'(i) == lo_idx) begin
        lo_v = lo_v | vals[i];
      end
      if (IW'(i) == hi_idx) begin
        hi_v = hi_v | vals[i];
      end
    end
  end

  // Sign-extend both before adding so the sum cannot wrap.
  assign sum = rmed_pkg::MEDIAN_BITS'($signed(lo_v)) + rmed_pkg::MEDIAN_BITS'($signed(hi_v));

endmodule

// File: design/running_median_unit.sv
// Top level of the running median unit: sorted cell row, count and result register.
//
//   channel | ports                         | direction | payload
//   input   | in_valid, in_ready, in_data   | in        | sample, restart
//   result  | out_valid, out_ready, out_data| out       | median_doubled, sample_count, overflow
//
// A sample is inserted into the cell row in the cycle of its transfer; every cell
// compares and shifts in parallel. The median is then taken from the registered cells
// and loaded into the result register once that register is free.
// One item per cycle is sustained while the result side keeps taking transfers.
// Reset clears the count and the handshake state; cell contents stay undefined.
// A stalled result register holds back one pending item, then in_ready drops.
module running_median_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmed_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmed_pkg::out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0] count_r, count_nxt;
  logic          pending_r, pending_nxt;
  logic          pend_ovf_r, pend_ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  rmed_pkg::out_item_t out_r, out_nxt;

  logic          in_acc;
  logic          out_load;
  logic [CW-1:0] eff_count;
  logic          full;

  logic signed [rmed_pkg::SAMPLE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]                     cell_gt;
  rmed_pkg::cell_ctrl_t                    cell_ctrl [CAPACITY];

  logic [CW-1:0] mid_hi_w, mid_lo_w;
  logic signed [rmed_pkg::MEDIAN_BITS-1:0] pick_sum;

  // Handshake: the result register is free or being emptied this cycle.
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !pending_r || out_load;
  assign in_acc   = in_valid && in_ready;

  // A restart empties the store before its sample is looked at.
  assign eff_count = in_data.restart ? '0 : count_r;
  assign full      = (eff_count == CAP_C);

  // Cell row with per-cell occupancy and free-slot marks.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [rmed_pkg::SAMPLE_BITS-1:0] left_val;
    logic                                    left_gt;

    assign cell_ctrl[i].insert   = in_acc && !full;
    assign cell_ctrl[i].occupied = CW'(i) < eff_count;
    assign cell_ctrl[i].slot     = CW'(i) == eff_count;

    if (i == 0) begin : g_first
      assign left_val = in_data.sample;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    rmed_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .new_sample (in_data.sample),
      .left_val   (left_val),
      .left_gt    (left_gt),
      .val        (cell_val[i]),
      .gt         (cell_gt[i])
    );
  end

  // Middle positions of the stored samples.
  assign mid_hi_w = count_r >> 1;
  assign mid_lo_w = (count_r - CW'(1)) >> 1;

  rmed_pick #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_pick (
    .vals   (cell_val),
    .lo_idx (mid_lo_w[IW-1:0]),
    .hi_idx (mid_hi_w[IW-1:0]),
    .sum    (pick_sum)
  );

  // Count and pending-item bookkeeping.
  always_comb begin
    count_nxt    = count_r;
    pending_nxt  = pending_r;
    pend_ovf_nxt = pend_ovf_r;
    if (in_acc) begin
      count_nxt    = full ? eff_count : eff_count + CW'(1);
      pending_nxt  = 1'b1;
      pend_ovf_nxt = full;
    end else if (out_load) begin
      pending_nxt = 1'b0;
    end
  end

  // Result register load.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = pending_r;
      if (pending_r) begin
        out_nxt.median_doubled = (count_r == '0) ? '0 : pick_sum;
        out_nxt.sample_count   = rmed_pkg::COUNT_BITS'(count_r);
        out_nxt.overflow       = pend_ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      pend_ovf_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      pend_ovf_r  <= pend_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("sample count above capacity");

  // A dropped sample is only reported with a full store.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && pend_ovf_r) |-> (count_r == CAP_C))
    else $error("overflow pending without a full store");

  // A sample that is taken in sets the count to one above the count it saw (zero after a restart).
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full) |=> (count_r == $past(eff_count) + CW'(1)))
    else $error("count did not advance on insertion");

  // A pending item that cannot move blocks the input side.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && !out_load) |-> !in_ready)
    else $error("input accepted while a pending item is stuck");

endmodule
